@@ hdl/rbi_pkg.sv @@
`timescale 1ns / 1ps
package rbi_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int SLACK_W    = 31;
    localparam int MAG_W      = DATA_W + FRAC_BITS;   // |plane - origin| << FRAC_BITS
    localparam int DIV_STAGES = MAG_W;                // one quotient bit per stage
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = 2 * DATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

    typedef struct packed {
        logic signed [DATA_W-1:0]  origin_x;
        logic signed [DATA_W-1:0]  origin_y;
        logic signed [DATA_W-1:0]  origin_z;
        logic signed [DATA_W-1:0]  direction_x;
        logic signed [DATA_W-1:0]  direction_y;
        logic signed [DATA_W-1:0]  direction_z;
        logic        [SLACK_W-1:0] slack_x;
        logic        [SLACK_W-1:0] slack_y;
        logic        [SLACK_W-1:0] slack_z;
    } t_in_item;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] hit_point_x;
        logic signed [DATA_W-1:0] hit_point_y;
        logic signed [DATA_W-1:0] hit_point_z;
    } t_out_item;

    typedef struct packed {
        logic [2:0][DATA_W-1:0] lo;
        logic [2:0][DATA_W-1:0] hi;
    } t_box;

    // per-ray data that rides alongside the dividers
    typedef struct packed {
        logic                    in_box;
        logic [2:0]              cand;
        logic [2:0]              neg;
        logic [2:0]              dzero;
        logic [2:0][DATA_W-1:0]  orig;
        logic [2:0][DATA_W-1:0]  dir;
        logic [2:0][DATA_W-1:0]  plane;
        logic [2:0][SLACK_W-1:0] slack;
    } t_side;

    // classified request, front to back
    typedef struct packed {
        t_side                 side;
        logic [2:0][MAG_W-1:0]  num;
        logic [2:0][DATA_W-1:0] den;
    } t_cls;

endpackage

@@ hdl/rbi_front.sv @@
`timescale 1ns / 1ps
module rbi_front (
    input  rbi_pkg::t_in_item i_item,
    input  rbi_pkg::t_box     i_box,
    output rbi_pkg::t_cls     o_cls
);

    logic signed [rbi_pkg::DATA_W-1:0] w_o [3];
    logic signed [rbi_pkg::DATA_W-1:0] w_d [3];
    logic [rbi_pkg::SLACK_W-1:0]       w_s [3];

    assign w_o[0] = i_item.origin_x;
    assign w_o[1] = i_item.origin_y;
    assign w_o[2] = i_item.origin_z;
    assign w_d[0] = i_item.direction_x;
    assign w_d[1] = i_item.direction_y;
    assign w_d[2] = i_item.direction_z;
    assign w_s[0] = i_item.slack_x;
    assign w_s[1] = i_item.slack_y;
    assign w_s[2] = i_item.slack_z;

    always_comb begin
        logic signed [rbi_pkg::DATA_W-1:0] lo;
        logic signed [rbi_pkg::DATA_W-1:0] hi;
        logic signed [rbi_pkg::DATA_W-1:0] pl;
        logic signed [rbi_pkg::DATA_W:0]   diff;
        logic [rbi_pkg::DATA_W:0]          dmag;
        logic [rbi_pkg::DATA_W:0]          nmag;
        o_cls = '0;
        for (int a = 0; a < 3; a++) begin
            lo = $signed(i_box.lo[a]);
            hi = $signed(i_box.hi[a]);
            pl = '0;
            // lower face tested first, as written even for inverted boxes
            if (w_o[a] < lo) begin
                pl = lo;
                o_cls.side.cand[a] = 1'b1;
            end else if (w_o[a] > hi) begin
                pl = hi;
                o_cls.side.cand[a] = 1'b1;
            end
            diff = {pl[rbi_pkg::DATA_W-1], pl} - {w_o[a][rbi_pkg::DATA_W-1], w_o[a]};
            nmag = diff[rbi_pkg::DATA_W] ? -diff : diff;
            dmag = w_d[a][rbi_pkg::DATA_W-1] ? -{1'b1, w_d[a]} : {1'b0, w_d[a]};
            o_cls.side.neg[a]   = (diff != '0) && (diff[rbi_pkg::DATA_W]
                                  ^ w_d[a][rbi_pkg::DATA_W-1]);
            o_cls.side.dzero[a] = (w_d[a] == '0);
            o_cls.side.orig[a]  = w_o[a];
            o_cls.side.dir[a]   = w_d[a];
            o_cls.side.plane[a] = pl;
            o_cls.side.slack[a] = w_s[a];
            o_cls.num[a] = {nmag[rbi_pkg::DATA_W-1:0], {rbi_pkg::FRAC_BITS{1'b0}}};
            o_cls.den[a] = dmag[rbi_pkg::DATA_W-1:0];
        end
        o_cls.side.in_box = ~|o_cls.side.cand;
    end

endmodule

@@ hdl/rbi_queue.sv @@
`timescale 1ns / 1ps
module rbi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rbi_pkg::t_cls i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output rbi_pkg::t_cls o_data
);

    rbi_pkg::t_cls r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

@@ hdl/rbi_div.sv @@
`timescale 1ns / 1ps
module rbi_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rbi_pkg::MAG_W-1:0]   i_num,
    input  logic [rbi_pkg::DATA_W-1:0]  i_den,
    output logic [rbi_pkg::MAG_W-1:0]   o_quo
);

    // restoring divider, one quotient bit per stage; numerator shifts out
    // at the top while quotient bits shift in at the bottom
    logic [rbi_pkg::DATA_W-1:0] r_rem [rbi_pkg::DIV_STAGES];
    logic [rbi_pkg::MAG_W-1:0]  r_nq  [rbi_pkg::DIV_STAGES];
    logic [rbi_pkg::DATA_W-1:0] r_den [rbi_pkg::DIV_STAGES];

    for (genvar k = 0; k < rbi_pkg::DIV_STAGES; k++) begin : g_stage
        logic [rbi_pkg::DATA_W-1:0] src_rem;
        logic [rbi_pkg::MAG_W-1:0]  src_nq;
        logic [rbi_pkg::DATA_W-1:0] src_den;
        logic [rbi_pkg::DATA_W:0]   trial;
        logic [rbi_pkg::DATA_W:0]   diff;
        logic                       ge;

        if (k == 0) begin : g_first
            assign src_rem = '0;
            assign src_nq  = i_num;
            assign src_den = i_den;
        end else begin : g_next
            assign src_rem = r_rem[k-1];
            assign src_nq  = r_nq[k-1];
            assign src_den = r_den[k-1];
        end

        assign trial = {src_rem, src_nq[rbi_pkg::MAG_W-1]};
        assign diff  = trial - {1'b0, src_den};
        assign ge    = !diff[rbi_pkg::DATA_W];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[rbi_pkg::DATA_W-1:0] : trial[rbi_pkg::DATA_W-1:0];
                r_nq[k]  <= {src_nq[rbi_pkg::MAG_W-2:0], ge};
                r_den[k] <= src_den;
            end
        end
    end

    assign o_quo = r_nq[rbi_pkg::DIV_STAGES-1];

endmodule

@@ hdl/rbi_back.sv @@
`timescale 1ns / 1ps
module rbi_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbi_pkg::t_box      i_box,
    input  logic               i_valid,
    input  rbi_pkg::t_cls      i_cls,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rbi_pkg::t_out_item o_out_item
);

    localparam int DW = rbi_pkg::DATA_W;
    localparam int MW = rbi_pkg::MAG_W;
    localparam int LAST = rbi_pkg::DIV_STAGES - 1;
    localparam logic signed [DW-1:0] MINUS_ONE = -(DW'(1) <<< rbi_pkg::FRAC_BITS);
    localparam logic signed [rbi_pkg::PROD_W-1:0] P_MAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
    localparam logic signed [rbi_pkg::PROD_W-1:0] P_MIN = -(64'sd1 <<< (DW - 1));
    localparam logic [MW-1:0] Q_POS_MAX = MW'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [MW-1:0] Q_NEG_MAX = MW'(64'd1 << (DW - 1));

    logic w_en;
    assign w_en  = !o_out_valid || i_out_ready;
    assign o_pop = w_en && i_valid;

    // dividers
    logic [rbi_pkg::MAG_W-1:0] w_quo [3];
    for (genvar a = 0; a < 3; a++) begin : g_div
        rbi_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (i_cls.num[a]),
            .i_den (i_cls.den[a]),
            .o_quo (w_quo[a])
        );
    end

    // sideband line matching the divider depth
    rbi_pkg::t_side r_side [rbi_pkg::DIV_STAGES];
    logic [rbi_pkg::DIV_STAGES-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= i_cls.side;
            for (int k = 1; k < rbi_pkg::DIV_STAGES; k++) r_side[k] <= r_side[k-1];
        end
    end

    // stage A: signed, saturated distances
    rbi_pkg::t_side             r_a_side;
    logic                       r_a_vld;
    logic signed [DW-1:0]       r_a_t [3];
    logic signed [DW-1:0]       n_a_t [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (!r_side[LAST].cand[a] || r_side[LAST].dzero[a]) begin
                n_a_t[a] = MINUS_ONE;
            end else if (!r_side[LAST].neg[a]) begin
                n_a_t[a] = (w_quo[a] > Q_POS_MAX) ? P_MAX[DW-1:0] : w_quo[a][DW-1:0];
            end else begin
                n_a_t[a] = (w_quo[a] > Q_NEG_MAX) ? P_MIN[DW-1:0] : -w_quo[a][DW-1:0];
            end
        end
    end

    // stage B: entry plane, ties to lower axis
    rbi_pkg::t_side       r_b_side;
    logic                 r_b_vld;
    logic [1:0]           r_b_win;
    logic signed [DW-1:0] r_b_t;
    logic [1:0]           n_b_win;
    logic signed [DW-1:0] n_b_t;

    always_comb begin
        n_b_win = 2'd0;
        n_b_t   = r_a_t[0];
        if (r_a_t[1] > n_b_t) begin
            n_b_win = 2'd1;
            n_b_t   = r_a_t[1];
        end
        if (r_a_t[2] > n_b_t) begin
            n_b_win = 2'd2;
            n_b_t   = r_a_t[2];
        end
    end

    // stage C: t * direction
    rbi_pkg::t_side                    r_c_side;
    logic                              r_c_vld;
    logic [1:0]                        r_c_win;
    logic signed [DW-1:0]              r_c_t;
    logic signed [rbi_pkg::PROD_W-1:0] r_c_prod [3];

    // stage D: point, widened-box test, result
    rbi_pkg::t_out_item n_out;

    always_comb begin
        logic signed [rbi_pkg::PROD_W-1:0] sh;
        logic signed [DW-1:0]              prod;
        logic signed [DW:0]                sum;
        logic signed [DW-1:0]              p [3];
        logic signed [DW+1:0]              lo_w;
        logic signed [DW+1:0]              hi_w;
        logic                              fail;
        fail = 1'b0;
        for (int a = 0; a < 3; a++) begin
            sh = r_c_prod[a] >>> rbi_pkg::FRAC_BITS;
            if (sh > P_MAX)      prod = P_MAX[DW-1:0];
            else if (sh < P_MIN) prod = P_MIN[DW-1:0];
            else                 prod = sh[DW-1:0];
            sum = $signed({r_c_side.orig[a][DW-1], r_c_side.orig[a]})
                + $signed({prod[DW-1], prod});
            if (sum[DW] != sum[DW-1]) p[a] = sum[DW] ? P_MIN[DW-1:0] : P_MAX[DW-1:0];
            else                      p[a] = sum[DW-1:0];
            lo_w = $signed({{2{i_box.lo[a][DW-1]}}, i_box.lo[a]})
                 - $signed({3'b000, r_c_side.slack[a]});
            hi_w = $signed({{2{i_box.hi[a][DW-1]}}, i_box.hi[a]})
                 + $signed({3'b000, r_c_side.slack[a]});
            if (2'(a) == r_c_win) begin
                p[a] = r_c_side.plane[a];
            end else if ($signed({{2{p[a][DW-1]}}, p[a]}) < lo_w
                      || $signed({{2{p[a][DW-1]}}, p[a]}) > hi_w) begin
                fail = 1'b1;
            end
        end
        n_out = '0;
        if (r_c_side.in_box) begin
            n_out.hit         = 1'b1;
            n_out.hit_point_x = r_c_side.orig[0];
            n_out.hit_point_y = r_c_side.orig[1];
            n_out.hit_point_z = r_c_side.orig[2];
        end else if (!r_c_t[DW-1] && !fail) begin
            n_out.hit         = 1'b1;
            n_out.hit_point_x = p[0];
            n_out.hit_point_y = p[1];
            n_out.hit_point_z = p[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_c_vld     <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            r_a_vld     <= r_vld[LAST];
            r_b_vld     <= r_a_vld;
            r_c_vld     <= r_b_vld;
            o_out_valid <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_side <= r_side[LAST];
            r_a_t    <= n_a_t;
            r_b_side <= r_a_side;
            r_b_win  <= n_b_win;
            r_b_t    <= n_b_t;
            r_c_side <= r_b_side;
            r_c_win  <= r_b_win;
            r_c_t    <= r_b_t;
            for (int a = 0; a < 3; a++) begin
                r_c_prod[a] <= r_b_t * $signed(r_b_side.dir[a]);
            end
            if (r_c_vld) o_out_item <= n_out;
        end
    end

endmodule

@@ hdl/ray_box_intersect_core.sv @@
`timescale 1ns / 1ps
// Ray against axis-aligned box, candidate-plane method, signed Q16.16.
// The box comes from six config registers (min x/y/z at index 0..2, max
// x/y/z at 3..5, reset 0; other indexes ignored); write them only while
// no request is in flight. Each input request is one ray (origin, direction,
// per-axis slack) and yields exactly one result: hit flag plus entry point
// (origin when it lies inside the box, zeros on a miss). One request is
// taken per clock when the output side keeps up. From a taken request to its
// result: the front classifies and writes a two-entry queue, the back runs
// three pipelined restoring dividers at one quotient bit per stage, giving
// Q16.16 distances, then distance saturation, entry-plane select, multiply,
// and the widened-box check into the output register. A stall on the output
// freezes the back pipeline; the queue then fills and drops o_in_ready.
module ray_box_intersect_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rbi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rbi_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rbi_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rbi_pkg::t_out_item                o_out_item
);

    // box registers
    rbi_pkg::t_box r_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbi_pkg::REG_MIN_X: r_box.lo[0] <= i_cfg_data;
                rbi_pkg::REG_MIN_Y: r_box.lo[1] <= i_cfg_data;
                rbi_pkg::REG_MIN_Z: r_box.lo[2] <= i_cfg_data;
                rbi_pkg::REG_MAX_X: r_box.hi[0] <= i_cfg_data;
                rbi_pkg::REG_MAX_Y: r_box.hi[1] <= i_cfg_data;
                rbi_pkg::REG_MAX_Z: r_box.hi[2] <= i_cfg_data;
                default: ;   // unused index, write dropped
            endcase
        end
    end

    // front: classify each axis, form numerator/divisor magnitudes
    rbi_pkg::t_cls w_cls;

    rbi_front u_front (
        .i_item (i_in_item),
        .i_box  (r_box),
        .o_cls  (w_cls)
    );

    // queue decouples request acceptance from the back pipeline stall
    rbi_pkg::t_cls w_q_data;
    logic          w_q_full;
    logic          w_q_empty;
    logic          w_pop;

    assign o_in_ready = !w_q_full;

    rbi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (w_cls),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    // back: divide, pick entry plane, project, check, deliver
    rbi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box       (r_box),
        .i_valid     (!w_q_empty),
        .i_cls       (w_q_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ tb/sv/ray_box_checker.sv @@
`timescale 1ns / 1ps
module ray_box_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rbi_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rbi_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  rbi_pkg::t_in_item             i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  rbi_pkg::t_out_item            i_out_item,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_hits,
    output int                            o_misses
);

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    longint box_lo [3];
    longint box_hi [3];
    rbi_pkg::t_out_item entry_q [$];

    function automatic longint clamp32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // arithmetic shift floors for negatives
    function automatic longint floor_frac(longint v);
        return v >>> rbi_pkg::FRAC_BITS;
    endfunction

    function automatic rbi_pkg::t_out_item trace_ray(rbi_pkg::t_in_item r);
        longint org [3];
        longint dir [3];
        longint slk [3];
        longint tval [3];
        longint pt [3];
        longint num;
        longint plane;
        bit     in_box;
        bit     cand;
        int     win;
        rbi_pkg::t_out_item res;
        org[0] = r.origin_x;    org[1] = r.origin_y;    org[2] = r.origin_z;
        dir[0] = r.direction_x; dir[1] = r.direction_y; dir[2] = r.direction_z;
        slk[0] = r.slack_x;     slk[1] = r.slack_y;     slk[2] = r.slack_z;
        in_box = 1;
        res = '0;
        for (int a = 0; a < 3; a++) begin
            cand = 0;
            plane = 0;
            tval[a] = -(64'sd1 <<< rbi_pkg::FRAC_BITS);
            pt[a] = 0;
            if (org[a] < box_lo[a]) begin
                plane = box_lo[a];
                cand = 1;
            end else if (org[a] > box_hi[a]) begin
                plane = box_hi[a];
                cand = 1;
            end
            if (cand) begin
                in_box = 0;
                pt[a] = plane;
                if (dir[a] != 0) begin
                    num = (plane - org[a]) * (64'sd1 <<< rbi_pkg::FRAC_BITS);
                    tval[a] = clamp32(num / dir[a]);
                end
            end
        end
        if (in_box) begin
            res.hit = 1'b1;
            res.hit_point_x = org[0][31:0];
            res.hit_point_y = org[1][31:0];
            res.hit_point_z = org[2][31:0];
            return res;
        end
        win = 0;
        if (tval[1] > tval[win]) win = 1;
        if (tval[2] > tval[win]) win = 2;
        if (tval[win] < 0) return res;
        for (int a = 0; a < 3; a++) begin
            if (a != win) begin
                pt[a] = clamp32(org[a] + clamp32(floor_frac(tval[win] * dir[a])));
                if (pt[a] < box_lo[a] - slk[a] || pt[a] > box_hi[a] + slk[a]) return res;
            end
        end
        res.hit = 1'b1;
        res.hit_point_x = pt[0][31:0];
        res.hit_point_y = pt[1][31:0];
        res.hit_point_z = pt[2][31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        rbi_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                box_lo[a] = 0;
                box_hi[a] = 0;
            end
            entry_q.delete();
            o_errors = 0;
            o_hits = 0;
            o_misses = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rbi_pkg::REG_MIN_X: box_lo[0] = $signed(i_cfg_data);
                    rbi_pkg::REG_MIN_Y: box_lo[1] = $signed(i_cfg_data);
                    rbi_pkg::REG_MIN_Z: box_lo[2] = $signed(i_cfg_data);
                    rbi_pkg::REG_MAX_X: box_hi[0] = $signed(i_cfg_data);
                    rbi_pkg::REG_MAX_Y: box_hi[1] = $signed(i_cfg_data);
                    rbi_pkg::REG_MAX_Z: box_hi[2] = $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (entry_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_item);
                    o_errors++;
                end else begin
                    want = entry_q.pop_front();
                    if (want.hit) o_hits++; else o_misses++;
                    if (want.hit != i_out_item.hit ||
                        want.hit_point_x != i_out_item.hit_point_x ||
                        want.hit_point_y != i_out_item.hit_point_y ||
                        want.hit_point_z != i_out_item.hit_point_z) begin
                        $display("%0t: mismatch exp hit=%b p=(%h %h %h) got hit=%b p=(%h %h %h)",
                                 $time, want.hit, want.hit_point_x, want.hit_point_y,
                                 want.hit_point_z, i_out_item.hit, i_out_item.hit_point_x,
                                 i_out_item.hit_point_y, i_out_item.hit_point_z);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) entry_q.push_back(trace_ray(i_in_item));
        end
        o_pending = entry_q.size();
    end
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

    localparam int LATENCY = rbi_pkg::DIV_STAGES + 5;
    localparam logic [rbi_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                          i_clk = 0;
    logic                          i_rst_n = 0;
    logic                          cfg_we = 0;
    logic [rbi_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [rbi_pkg::DATA_W-1:0]    cfg_data = '0;
    logic                          in_valid = 0;
    logic                          in_ready;
    rbi_pkg::t_in_item             in_item = '0;
    logic                          out_valid;
    logic                          out_ready = 0;
    rbi_pkg::t_out_item            out_item;
    int                            errors, pending, hits, misses;

    // receiver behavior, set by the stimulus thread
    bit                   stall_rand = 1;    // random hold-offs on the output
    int                   hold_cycles = 0;   // one long hold-off, counted below

    always #1 i_clk = ~i_clk;

    ray_box_intersect_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item)
    );

    ray_box_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .o_errors(errors), .o_pending(pending), .o_hits(hits), .o_misses(misses)
    );

    // Receiver: ready changes on the falling edge. A requested hold-off keeps ready
    // low while hold_cycles counts down, otherwise ~19% random stalls (none when stall_rand is off).
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_rand) begin
            out_ready <= ($urandom_range(99) >= 19);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Biased 32-bit value: corners, small Q16.16 numbers, or anything.
    function automatic logic [31:0] pick32();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom;
            default: return $urandom_range(40 << 16) - (20 << 16);
        endcase
    endfunction

    function automatic logic [30:0] pick_slack();
        case ($urandom_range(7))
            0: return '0;
            1: return 31'h7fff_ffff;
            2: return 31'($urandom);
            default: return 31'($urandom_range(1 << 16));
        endcase
    endfunction

    // Ray from a random origin aimed toward the box region, with random content.
    function automatic rbi_pkg::t_in_item aimed_ray();
        rbi_pkg::t_in_item r;
        r.origin_x    = $urandom_range(60 << 16) - (30 << 16);
        r.origin_y    = $urandom_range(60 << 16) - (30 << 16);
        r.origin_z    = $urandom_range(60 << 16) - (30 << 16);
        r.direction_x = 32'(-$signed(r.origin_x) / 16)
                      + 32'($urandom_range(1 << 16)) - 32'(1 << 15);
        r.direction_y = 32'(-$signed(r.origin_y) / 16)
                      + 32'($urandom_range(1 << 16)) - 32'(1 << 15);
        r.direction_z = 32'(-$signed(r.origin_z) / 16)
                      + 32'($urandom_range(1 << 16)) - 32'(1 << 15);
        if ($urandom_range(5) == 0) r.direction_y = 0;
        r.slack_x = pick_slack();
        r.slack_y = pick_slack();
        r.slack_z = pick_slack();
        return r;
    endfunction

    function automatic rbi_pkg::t_in_item noise_ray();
        rbi_pkg::t_in_item r;
        r.origin_x = pick32();    r.origin_y = pick32();    r.origin_z = pick32();
        r.direction_x = pick32(); r.direction_y = pick32(); r.direction_z = pick32();
        r.slack_x = pick_slack(); r.slack_y = pick_slack(); r.slack_z = pick_slack();
        return r;
    endfunction

    task automatic write_reg(input logic [rbi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_box(input logic [31:0] lx, ly, lz, hx, hy, hz);
        write_reg(rbi_pkg::REG_MIN_X, lx);
        write_reg(rbi_pkg::REG_MIN_Y, ly);
        write_reg(rbi_pkg::REG_MIN_Z, lz);
        write_reg(rbi_pkg::REG_MAX_X, hx);
        write_reg(rbi_pkg::REG_MAX_Y, hy);
        write_reg(rbi_pkg::REG_MAX_Z, hz);
    endtask

    // Offer one request; valid stays up across back-to-back requests.
    task automatic send_ray(input rbi_pkg::t_in_item r, input bit gaps);
        while (gaps && $urandom_range(99) < 19) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= r;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic random_phase(input int count, input bit gaps);
        for (int n = 0; n < count; n++)
            send_ray(($urandom_range(3) == 0) ? noise_ray() : aimed_ray(), gaps);
    endtask

    initial begin
        rbi_pkg::t_in_item r;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset box is a point at zero: one ray inside it, one parallel miss
        r = '0;
        send_ray(r, 0);
        r.origin_x = 32'h0001_0000;
        send_ray(r, 0);
        drain();

        // directed: unit box around the origin
        load_box(-32'sd65536, -32'sd65536, -32'sd65536, 32'd65536, 32'd65536, 32'd65536);
        write_reg(REG_UNUSED, 32'hdead_beef);   // out-of-range index, ignored
        r = '0; send_ray(r, 0);                              // inside
        r.origin_x = -(5 << 16); r.direction_x = 1 << 16;    // straight hit on x
        send_ray(r, 0);
        r.direction_x = -(1 << 16); send_ray(r, 0);          // pointing away: miss
        r.direction_x = 0; send_ray(r, 0);                   // parallel outside: miss
        r = '0; r.origin_x = -(3 << 16); r.origin_y = -(3 << 16);
        r.direction_x = 1 << 16; r.direction_y = 1 << 16;    // tie x/y, x wins
        send_ray(r, 0);
        r = '0; r.origin_x = -(3 << 16); r.origin_y = 5 << 16;
        r.direction_x = 1 << 16;                             // off-box on y
        send_ray(r, 0);
        r.slack_y = 31'h7fff_ffff; send_ray(r, 0);           // saved by the slack
        r = '0; r.origin_x = 32'h8000_0000; r.origin_y = 32'h7fff_ffff;
        r.origin_z = 32'h8000_0000; r.direction_x = 32'h7fff_ffff;
        r.direction_y = 32'h8000_0000; r.direction_z = 32'h0000_0001;
        send_ray(r, 0);                                      // saturating extremes
        r.direction_x = 32'h0000_0001; r.direction_z = 32'h7fff_ffff;
        r.slack_x = 31'h7fff_ffff; r.slack_z = 31'h7fff_ffff;
        send_ray(r, 0);
        r = '1; send_ray(r, 0);
        drain();

        // full-range box, then an inverted one
        load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        r = '1; send_ray(r, 0);
        random_phase(8, 1);
        drain();
        load_box(32'd65536, 32'd65536, 32'd65536, -32'sd65536, -32'sd65536, -32'sd65536);
        random_phase(60, 1);
        drain();

        // main random phases, each with its own box
        for (int ph = 0; ph < 6; ph++) begin
            load_box(-(($urandom_range(8) + 1) << 16), -(($urandom_range(8) + 1) << 16),
                     -(($urandom_range(8) + 1) << 16), ($urandom_range(8) + 1) << 16,
                     ($urandom_range(8) + 1) << 16, ($urandom_range(8) + 1) << 16);
            case (ph)
                1: begin   // no idling on either side
                    stall_rand = 0;
                    random_phase(170, 0);
                    stall_rand = 1;
                end
                3: begin   // long output hold-off while requests keep coming
                    hold_cycles = 3 * LATENCY;
                    random_phase(170, 0);
                end
                default: random_phase(170, 1);
            endcase
            drain();       // sender pauses until every result is back
        end

        $display("Ran about 1100 rays over %0d box settings: %0d hits, %0d misses.",
                 10, hits, misses);
        $display("Covered inside, parallel, tie, slack, saturation and inverted-box cases.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/rbi_pkg.sv
hdl/rbi_front.sv
hdl/rbi_queue.sv
hdl/rbi_div.sv
hdl/rbi_back.sv
hdl/ray_box_intersect_core.sv
tb/sv/ray_box_checker.sv
tb/sv/testbench.sv
